>>> sv/assert_macros.svh
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// property checked during reset too
`define ASSERT_PROP_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_PROP_NR(lbl, clk, prop)
`endif

`endif

>>> sv/mmf_pkg.sv
// shared constants, types and sorting network layers of the median filter
`default_nettype none

package mmf_pkg;

   localparam int WINDOW   = 5;
   localparam int CHANNELS = 4;
   localparam int CH_W     = 2;
   localparam int SMP_W    = 32;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int MID      = WINDOW / 2;
   localparam int LAYERS   = 5;
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   typedef logic [SMP_W-1:0] sample_type;
   typedef sample_type [WINDOW-1:0] win_type;

   typedef struct packed {
      logic [CH_W-1:0] channel;
      win_type         window;
   } job_type;

   // compare-exchange, smaller signed value ends at lo
   function automatic win_type cmp_swap(win_type w, int lo, int hi);
      win_type r;
      r = w;
      if ($signed(w[lo]) > $signed(w[hi])) begin
         r[lo] = w[hi];
         r[hi] = w[lo];
      end
      return r;
   endfunction

   // one layer of the five-input sorting network
   function automatic win_type sort_layer(win_type w, int layer);
      win_type r;
      r = w;
      case (layer)
         0: begin
            r = cmp_swap(r, 0, 3);
            r = cmp_swap(r, 1, 4);
         end
         1: begin
            r = cmp_swap(r, 0, 2);
            r = cmp_swap(r, 1, 3);
         end
         2: begin
            r = cmp_swap(r, 0, 1);
            r = cmp_swap(r, 2, 4);
         end
         3: begin
            r = cmp_swap(r, 1, 2);
            r = cmp_swap(r, 3, 4);
         end
         4: begin
            r = cmp_swap(r, 2, 3);
         end
         default: begin
            r = w;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/mmf_front.sv
// front end: sample rings, write pointers and job building
`default_nettype none

module mmf_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [mmf_pkg::CH_W-1:0]  req_channel,
   input  wire logic [mmf_pkg::SMP_W-1:0] req_sample,
   input  wire logic                      q_ready,
   output logic                           q_push,
   output mmf_pkg::job_type               q_job
);

   mmf_pkg::win_type                    window_ff [mmf_pkg::CHANNELS];
   mmf_pkg::win_type                    window_in [mmf_pkg::CHANNELS];
   logic [mmf_pkg::SLOT_W-1:0]          slot_ff   [mmf_pkg::CHANNELS];
   logic [mmf_pkg::SLOT_W-1:0]          slot_in   [mmf_pkg::CHANNELS];
   logic [mmf_pkg::SLOT_W-1:0]          slot;
   logic                                present;
   logic                                accept;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;
   assign q_push     = accept;
   assign present    = int'(req_channel) < mmf_pkg::CHANNELS;
   assign slot       = slot_ff[req_channel];

   // window as it stands after this sample is written
   always_comb begin
      q_job.channel = req_channel;
      for (int i = 0; i < mmf_pkg::WINDOW; i++) begin
         if (!present) begin
            q_job.window[i] = '0;
         end else if (mmf_pkg::SLOT_W'(i) == slot) begin
            q_job.window[i] = req_sample;
         end else begin
            q_job.window[i] = window_ff[req_channel][i];
         end
      end
   end

   always_comb begin
      window_in = window_ff;
      slot_in   = slot_ff;
      if (accept && present) begin
         window_in[req_channel][slot] = req_sample;
         if (slot == mmf_pkg::SLOT_W'(mmf_pkg::WINDOW - 1)) begin
            slot_in[req_channel] = '0;
         end else begin
            slot_in[req_channel] = slot + mmf_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < mmf_pkg::CHANNELS; c++) begin
            window_ff[c] <= '0;
            slot_ff[c]   <= '0;
         end
      end else begin
         window_ff <= window_in;
         slot_ff   <= slot_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/mmf_queue.sv
// short job queue between front end and sorting pipeline
`default_nettype none

module mmf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mmf_pkg::job_type push_job,
   output logic                  ready,
   input  wire logic             pop,
   output logic                  valid,
   output mmf_pkg::job_type      head
);

   mmf_pkg::job_type             entry_ff [mmf_pkg::Q_DEPTH];
   logic [mmf_pkg::Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mmf_pkg::Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mmf_pkg::Q_CNT_W-1:0]  count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign ready   = count_ff != mmf_pkg::Q_CNT_W'(mmf_pkg::Q_DEPTH);
   assign valid   = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && ready;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mmf_pkg::Q_PTR_W'(mmf_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mmf_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mmf_pkg::Q_PTR_W'(mmf_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mmf_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + mmf_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - mmf_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> sv/mmf_sort.sv
// back end: pipelined five-input sorting network, result taken from its last layer
`default_nettype none

module mmf_sort (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_valid,
   input  wire mmf_pkg::job_type          q_job,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [mmf_pkg::CH_W-1:0]       rsp_tuser,
   output logic [mmf_pkg::SMP_W-1:0]      rsp_tdata
);

   logic [mmf_pkg::LAYERS-1:0] valid_ff, valid_in;
   mmf_pkg::job_type           data_ff [mmf_pkg::LAYERS];
   mmf_pkg::job_type           data_in [mmf_pkg::LAYERS];
   mmf_pkg::job_type           src     [mmf_pkg::LAYERS];
   logic [mmf_pkg::LAYERS-1:0] src_valid;
   logic [mmf_pkg::LAYERS-1:0] adv;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      adv[mmf_pkg::LAYERS-1] = !valid_ff[mmf_pkg::LAYERS-1] || rsp_tready;
      for (int k = mmf_pkg::LAYERS - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign q_pop = q_valid && adv[0];

   for (genvar k = 0; k < mmf_pkg::LAYERS; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_valid[k] = q_valid;
         assign src[k]       = q_job;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src[k]       = data_ff[k-1];
      end

      assign valid_in[k]        = adv[k] ? src_valid[k] : valid_ff[k];
      assign data_in[k].channel = src[k].channel;
      assign data_in[k].window  = mmf_pkg::sort_layer(src[k].window, k);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k] && src_valid[k]) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   assign rsp_tvalid = valid_ff[mmf_pkg::LAYERS-1];
   assign rsp_tuser  = data_ff[mmf_pkg::LAYERS-1].channel;
   assign rsp_tdata  = data_ff[mmf_pkg::LAYERS-1].window[mmf_pkg::MID];

endmodule

`default_nettype wire

>>> sv/multichannel_median_filter.sv
// four-channel sliding-window median filter over five signed Q16.16 samples
//
// req channel: one sample per transaction, req_tuser selects the channel
// (left displacement, left speed, right displacement, right speed).
// rsp channel: one transaction per request, in order, carrying the channel
// and the median of that channel's last five samples.
// each channel keeps a ring of five samples and a write pointer; the new
// sample replaces the oldest and the median of the ring is reported.
// reset clears all rings to zero and all pointers to the first slot, so the
// first medians of a channel include those zeros.
// the job enters the queue at the accepting edge and then moves through the
// registers of the five sorting layers in order; rsp_tvalid rises once the
// last layer holds the job.
// throughput: one transaction per cycle; the front end takes a sample in
// every cycle the two-entry job queue has room.
// when rsp_tready is low the pipeline holds, the queue fills and req_tready
// drops; no transaction is lost or repeated.
`default_nettype none

`include "assert_macros.svh"

module multichannel_median_filter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [31:0] sample
   input  wire logic [1:0]   req_tuser,   // [1:0] channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] median
   output logic [1:0]        rsp_tuser    // [1:0] out_channel
);

   logic             q_push;
   logic             q_ready;
   logic             q_pop;
   logic             q_valid;
   mmf_pkg::job_type push_job;
   mmf_pkg::job_type head_job;

   mmf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_channel (req_tuser),
      .req_sample  (req_tdata),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   mmf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_job)
   );

   mmf_sort u_sort (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_PROP(a_push_has_room, clock, reset, q_push |-> q_ready)
   `ASSERT_PROP(a_push_shows_up, clock, reset, q_push |=> q_valid)
   `ASSERT_PROP_NR(a_reset_empties_output, clock, reset |=> !rsp_tvalid)

endmodule

`default_nettype wire
